// File: rtl/core/sosel_pkg.sv
// sosel_pkg: shared constants for the spiral-order element select block.
// Field widths, register indexes, action codes and default sizes.
// No dependencies.
package sosel_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int POS_W   = 13;
  localparam int CNT_W   = 7;

  // APB register file
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // input actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

// File: rtl/core/sosel_if.sv
// sosel_if: valid/ready channel interfaces for items and results.
// Depends on sosel_pkg for the field widths.
interface sosel_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [sosel_pkg::VALUE_W-1:0] element_value;
  logic [sosel_pkg::POS_W-1:0]  spiral_position;

  modport source (output valid, action, element_value, spiral_position, input ready);
  modport sink (input valid, action, element_value, spiral_position, output ready);
endinterface

interface sosel_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [sosel_pkg::VALUE_W-1:0] result_value;
  logic                         out_of_range;

  modport source (output valid, result_value, out_of_range, input ready);
  modport sink (input valid, result_value, out_of_range, output ready);
endinterface

// File: rtl/core/sosel_walk.sv
// sosel_walk: locates a 1-based spiral position as a row-major store address.
// One ring side per cycle through a shared compare/subtract unit, then an
// address state (W_ADDR). Depends on sosel_pkg.
module sosel_walk #(
  parameter int MAX_ROWS = sosel_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sosel_pkg::DEF_MAX_COLS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [sosel_pkg::POS_W-1:0] position,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols,
  output logic done,
  output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] addr
);

  localparam int PW     = sosel_pkg::POS_W;
  localparam int CNTR_W = $clog2(MAX_ROWS+1);
  localparam int CNTC_W = $clog2(MAX_COLS+1);
  localparam int RB_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = RB_W + CNTC_W;

  typedef enum logic [1:0] {W_IDLE, W_SEG, W_ADDR} wstate_t;
  typedef enum logic [1:0] {SEG_RIGHT, SEG_DOWN, SEG_LEFT, SEG_UP} seg_t;

  wstate_t          state;
  seg_t             seg;
  seg_t             seg_next;
  logic [RB_W-1:0]  top, bottom, rr;
  logic [CB_W-1:0]  left, right, cc;
  logic [PW-1:0]    rem;

  logic [PW-1:0]    len;
  logic [PW-1:0]    off;
  logic [PW-1:0]    base;
  logic [PW-1:0]    moved;
  logic             hit;
  logic [PROD_W-1:0] prod;

  // shared unit: side length, hit compare, and one offset add/sub
  always_comb begin
    case (seg)
      SEG_RIGHT: begin
        len      = PW'(right) - PW'(left) + PW'(1);
        base     = PW'(left);
        seg_next = SEG_DOWN;
      end
      SEG_DOWN: begin
        len      = PW'(bottom) - PW'(top) + PW'(1);
        base     = PW'(top);
        seg_next = SEG_LEFT;
      end
      SEG_LEFT: begin
        len      = PW'(right) - PW'(left) + PW'(1);
        base     = PW'(right);
        seg_next = SEG_UP;
      end
      SEG_UP: begin
        len      = PW'(bottom) - PW'(top) + PW'(1);
        base     = PW'(bottom);
        seg_next = SEG_RIGHT;
      end
      default: begin
        len      = '0;
        base     = '0;
        seg_next = SEG_RIGHT;
      end
    endcase
    off   = rem - PW'(1);
    hit   = (rem <= len);
    moved = (seg == SEG_LEFT || seg == SEG_UP) ? (base - off) : (base + off);
  end

  assign prod = PROD_W'(rr) * PROD_W'(cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            top    <= '0;
            left   <= '0;
            bottom <= RB_W'(rows - CNTR_W'(1));
            right  <= CB_W'(cols - CNTC_W'(1));
            rem    <= position;
            seg    <= SEG_RIGHT;
            state  <= W_SEG;
          end
        end
        W_SEG: begin
          if (hit) begin
            case (seg)
              SEG_RIGHT: begin rr <= top;    cc <= CB_W'(moved); end
              SEG_DOWN:  begin rr <= RB_W'(moved); cc <= right;  end
              SEG_LEFT:  begin rr <= bottom; cc <= CB_W'(moved); end
              SEG_UP:    begin rr <= RB_W'(moved); cc <= left;   end
              default:   begin rr <= top;    cc <= left;         end
            endcase
            state <= W_ADDR;
          end else begin
            rem <= rem - len;
            case (seg)
              SEG_RIGHT: top    <= top + RB_W'(1);
              SEG_DOWN:  right  <= right - CB_W'(1);
              SEG_LEFT:  bottom <= bottom - RB_W'(1);
              SEG_UP:    left   <= left + CB_W'(1);
              default:   top    <= top;
            endcase
            seg <= seg_next;
          end
        end
        W_ADDR: begin
          addr  <= AW'(prod + PROD_W'(cc));
          done  <= 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/spiral_order_element_select.sv
// spiral_order_element_select: matrix store with spiral-order query.
// Depends on sosel_pkg, sosel_if (item/result channels) and sosel_walk.
//
//   channel  dir  handshake          payload
//   item     in   valid/ready        action, element_value, spiral_position
//   result   out  valid/ready        result_value, out_of_range
//   apb      in   psel/penable/pwrite row_count @0x0, col_count @0x4
//
// Load: written on acceptance. Out-of-range query: skips the walk; the result
// goes from S_DONE into the result register. Valid query: one ring side per
// cycle in sosel_walk (at most 2*min(rows,cols) sides), then address, store
// read and result register cycles. Items wait while a query runs or its result
// finds the result register full. Reset clears the load pointer and sets both
// counts to 1; the store is not cleared.
module spiral_order_element_select #(
  parameter int MAX_ROWS   = sosel_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = sosel_pkg::DEF_MAX_COLS,
  parameter int DATA_WIDTH = sosel_pkg::DEF_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  sosel_in_if.sink    item,
  sosel_out_if.source result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sosel_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sosel_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sosel_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int VW     = sosel_pkg::VALUE_W;
  localparam int PW     = sosel_pkg::POS_W;
  localparam int CW     = sosel_pkg::CNT_W;
  localparam int CNTR_W = $clog2(MAX_ROWS+1);
  localparam int CNTC_W = $clog2(MAX_COLS+1);
  localparam int ROW_EW = (CW > CNTR_W) ? CW : CNTR_W;
  localparam int COL_EW = (CW > CNTC_W) ? CW : CNTC_W;
  localparam int TOT_W  = CNTR_W + CNTC_W;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LPC_W  = ((AW > TOT_W) ? AW : TOT_W) + 1;
  localparam int QC_W   = ((PW > TOT_W) ? PW : TOT_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t state;

  logic [CW-1:0]          row_count, col_count;
  logic [ROW_EW-1:0]      row_ext;
  logic [COL_EW-1:0]      col_ext;
  logic [CNTR_W-1:0]      eff_rows;
  logic [CNTC_W-1:0]      eff_cols;
  logic [TOT_W-1:0]       total;

  logic [AW-1:0]          load_pointer;
  logic [AW-1:0]          wr_ptr;
  logic [LPC_W-1:0]       wr_inc;
  logic [AW-1:0]          load_pointer_next;

  logic [DATA_WIDTH-1:0]  mem [DEPTH];
  logic [DATA_WIDTH-1:0]  wr_data;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic [VW-1:0]          rd_value;

  logic                   accept;
  logic                   is_load;
  logic                   pos_bad;
  logic                   walk_start;
  logic                   walk_done;
  logic [AW-1:0]          walk_addr;
  logic                   oor;
  logic                   cfg_wr;

  logic                   res_load;
  logic                   res_valid;
  logic                   res_oor;
  logic [VW-1:0]          res_value;

  // effective counts: zero reads as one, anything above the maximum clamps
  always_comb begin
    row_ext = ROW_EW'(row_count);
    col_ext = COL_EW'(col_count);
    if (row_ext == '0)
      eff_rows = CNTR_W'(1);
    else if (row_ext > ROW_EW'(MAX_ROWS))
      eff_rows = CNTR_W'(MAX_ROWS);
    else
      eff_rows = CNTR_W'(row_ext);
    if (col_ext == '0)
      eff_cols = CNTC_W'(1);
    else if (col_ext > COL_EW'(MAX_COLS))
      eff_cols = CNTC_W'(MAX_COLS);
    else
      eff_cols = CNTC_W'(col_ext);
  end

  assign total = TOT_W'(eff_rows) * TOT_W'(eff_cols);

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sosel_pkg::REG_COL_COUNT) ?
                  sosel_pkg::APB_DATA_W'(col_count) : sosel_pkg::APB_DATA_W'(row_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CW'(1);
      col_count <= CW'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == sosel_pkg::REG_ROW_COUNT)
        row_count <= pwdata[CW-1:0];
      else
        col_count <= pwdata[CW-1:0];
    end
  end

  // item handshake
  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign is_load    = (item.action == sosel_pkg::ACT_LOAD);
  assign pos_bad    = (item.spiral_position == '0) ||
                      (QC_W'(item.spiral_position) > QC_W'(total));
  assign walk_start = accept && !is_load && !pos_bad;

  // load pointer; a pointer left past a shrunken matrix restarts at zero
  always_comb begin
    wr_ptr = (LPC_W'(load_pointer) >= LPC_W'(total)) ? '0 : load_pointer;
    wr_inc = LPC_W'(wr_ptr) + LPC_W'(1);
    load_pointer_next = (wr_inc >= LPC_W'(total)) ? '0 : AW'(wr_inc);
  end

  always_ff @(posedge clk) begin
    if (rst)
      load_pointer <= '0;
    else if (accept && is_load)
      load_pointer <= load_pointer_next;
  end

  // element width adaptation: sign-extend or truncate in, zero-extend or truncate out
  generate
    if (DATA_WIDTH > VW) begin : g_wide
      assign wr_data  = {{(DATA_WIDTH-VW){item.element_value[VW-1]}}, item.element_value};
      assign rd_value = rd_data[VW-1:0];
    end else begin : g_narrow
      assign wr_data  = item.element_value[DATA_WIDTH-1:0];
      assign rd_value = VW'(rd_data);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (accept && is_load)
      mem[wr_ptr] <= wr_data;
    if (state == S_WALK && walk_done)
      rd_data <= mem[walk_addr];
  end

  sosel_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .position (item.spiral_position),
    .rows     (eff_rows),
    .cols     (eff_cols),
    .done     (walk_done),
    .addr     (walk_addr)
  );

  // finished query moves into the result register once it is free
  assign res_load = (state == S_DONE) && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
        res_oor   <= oor;
        res_value <= oor ? '0 : rd_value;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && !is_load) begin
            oor   <= pos_bad;
            state <= pos_bad ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done)
            state <= S_DONE;
        end
        S_DONE: begin
          if (res_load)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.out_of_range = res_oor;
  assign result.result_value = res_value;

endmodule

// File: tb/spiral_order_element_select_tb.sv
// Testbench for spiral_order_element_select: random and directed load/query traffic.
// Uses sosel_pkg and the sosel_in_if/sosel_out_if channels. Answers are checked
// against a spiral lookup model kept in the bench.
module spiral_order_element_select_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = sosel_pkg::DEF_MAX_ROWS * sosel_pkg::DEF_MAX_COLS;

  typedef struct {
    logic                                 action;
    logic signed [sosel_pkg::VALUE_W-1:0] value;
    logic [sosel_pkg::POS_W-1:0]          pos;
  } item_t;

  typedef struct {
    logic signed [sosel_pkg::VALUE_W-1:0] value;
    logic                                 oor;
  } answer_t;

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [sosel_pkg::APB_ADDR_W-1:0] paddr;
  logic [sosel_pkg::APB_DATA_W-1:0] pwdata;
  logic [sosel_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;

  sosel_in_if  item_if();
  sosel_out_if result_if();

  spiral_order_element_select uut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state
  logic [sosel_pkg::VALUE_W-1:0] matrix_mem [STORE_DEPTH];
  int                            load_ptr;
  logic [sosel_pkg::CNT_W-1:0]   row_reg;
  logic [sosel_pkg::CNT_W-1:0]   col_reg;

  item_t   item_q[$];
  answer_t answer_q[$];
  item_t   next_item;
  answer_t want;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      mismatches;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int eff_count(logic [sosel_pkg::CNT_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // store index of 1-based position k, peeling rings off the matrix
  function automatic int spiral_addr(int nr, int nc, int k);
    int top_row, bot_row, lo_col, hi_col, rem, row, col, len;
    top_row = 0;
    bot_row = nr - 1;
    lo_col = 0;
    hi_col = nc - 1;
    rem = k;
    row = 0;
    col = 0;
    while (top_row <= bot_row && lo_col <= hi_col) begin
      len = hi_col - lo_col + 1;
      if (rem <= len) begin
        row = top_row;
        col = lo_col + rem - 1;
        break;
      end
      rem -= len;
      top_row++;
      if (top_row > bot_row) break;
      len = bot_row - top_row + 1;
      if (rem <= len) begin
        row = top_row + rem - 1;
        col = hi_col;
        break;
      end
      rem -= len;
      hi_col--;
      if (lo_col > hi_col) break;
      len = hi_col - lo_col + 1;
      if (rem <= len) begin
        row = bot_row;
        col = hi_col - rem + 1;
        break;
      end
      rem -= len;
      bot_row--;
      if (top_row > bot_row) break;
      len = bot_row - top_row + 1;
      if (rem <= len) begin
        row = bot_row - rem + 1;
        col = lo_col;
        break;
      end
      rem -= len;
      lo_col++;
    end
    return (row * nc + col) % STORE_DEPTH;
  endfunction

  task automatic predict_answer(input item_t it);
    int      nr;
    int      nc;
    int      total;
    int      p;
    answer_t a;
    nr = eff_count(row_reg, sosel_pkg::DEF_MAX_ROWS);
    nc = eff_count(col_reg, sosel_pkg::DEF_MAX_COLS);
    total = nr * nc;
    if (it.action == sosel_pkg::ACT_LOAD) begin
      p = load_ptr;
      // counts may have shrunk under the pointer
      if (p >= total) p = 0;
      matrix_mem[p % STORE_DEPTH] = it.value;
      p++;
      if (p >= total) p = 0;
      load_ptr = p;
    end else begin
      if (it.pos == 0 || it.pos > total) begin
        a.value = '0;
        a.oor = 1'b1;
      end else begin
        a.value = matrix_mem[spiral_addr(nr, nc, it.pos)];
        a.oor = 1'b0;
      end
      answer_q.push_back(a);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || item_if.ready) begin
      if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = item_q.pop_front();
        item_if.action <= next_item.action;
        item_if.element_value <= next_item.value;
        item_if.spiral_position <= next_item.pos;
        item_if.valid <= 1'b1;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on item transaction, check on result transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready) begin
        predict_answer('{item_if.action, item_if.element_value, item_if.spiral_position});
      end
      if (result_if.valid && result_if.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result transaction with no query outstanding");
        end else begin
          want = answer_q.pop_front();
          if (result_if.result_value !== want.value)
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      result_if.result_value, want.value));
          if (result_if.out_of_range !== want.oor)
            report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                      result_if.out_of_range, want.oor));
        end
      end
    end
  end

  task automatic queue_item(input logic act, input logic [sosel_pkg::VALUE_W-1:0] val,
                            input logic [sosel_pkg::POS_W-1:0] pos);
    item_t it;
    it.action = act;
    it.value = val;
    it.pos = pos;
    item_q.push_back(it);
  endtask

  task automatic queue_load(input logic [sosel_pkg::VALUE_W-1:0] val);
    logic [31:0] junk_pos;
    junk_pos = $urandom();
    queue_item(sosel_pkg::ACT_LOAD, val, junk_pos[sosel_pkg::POS_W-1:0]);
  endtask

  task automatic queue_query(input int pos);
    queue_item(sosel_pkg::ACT_QUERY, $urandom(), pos[sosel_pkg::POS_W-1:0]);
  endtask

  // waits until every item is sent and answered, then lets a trailing load settle
  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || item_if.valid || answer_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic idx, input int val);
    logic [sosel_pkg::APB_DATA_W-1:0] junk;
    junk = $urandom();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk[sosel_pkg::APB_DATA_W-1:sosel_pkg::CNT_W], val[sosel_pkg::CNT_W-1:0]};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == sosel_pkg::REG_ROW_COUNT) row_reg = val[sosel_pkg::CNT_W-1:0];
    else col_reg = val[sosel_pkg::CNT_W-1:0];
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 55;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_idle_pct = 27;
        recv_stall_pct = 27;
      end
    endcase
  endtask

  task automatic queue_mixed(input int total, input int n);
    int sel;
    int val;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        val = $urandom_range(7);
        if (val == 0) queue_load(32'h8000_0000);
        else if (val == 1) queue_load(32'h7fff_ffff);
        else queue_load($urandom());
      end else begin
        sel = $urandom_range(99);
        if (sel < 80) queue_query($urandom_range(total, 1));
        else if (sel < 88) queue_query(0);
        else if (sel < 94) queue_query(total + 1);
        else queue_query($urandom_range(8191, total + 1));
      end
    end
  endtask

  // full matrix load first so no query lands on an unwritten entry,
  // then a pointer offset, then mixed traffic with a drain halfway
  task automatic run_phase(input int rows_val, input int cols_val, input int n,
                           input int mode);
    int total;
    write_count(sosel_pkg::REG_ROW_COUNT, rows_val);
    write_count(sosel_pkg::REG_COL_COUNT, cols_val);
    set_idling(mode);
    total = eff_count(rows_val[sosel_pkg::CNT_W-1:0], sosel_pkg::DEF_MAX_ROWS) *
            eff_count(cols_val[sosel_pkg::CNT_W-1:0], sosel_pkg::DEF_MAX_COLS);
    repeat (total) queue_load($urandom());
    repeat (3) queue_load($urandom());
    queue_mixed(total, n / 2);
    wait_drained();
    queue_mixed(total, n - n / 2);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_if.valid = 1'b0;
    item_if.action = sosel_pkg::ACT_LOAD;
    item_if.element_value = '0;
    item_if.spiral_position = '0;
    result_if.ready = 1'b0;
    load_ptr = 0;
    row_reg = 7'd1;
    col_reg = 7'd1;
    mismatches = 0;
    set_idling(0);
    foreach (matrix_mem[i]) matrix_mem[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset counts give a 1x1 matrix
    queue_load(32'h7fff_ffff);
    queue_query(1);
    queue_query(0);
    queue_query(2);
    queue_load(32'h8000_0000);
    queue_query(1);
    wait_drained();

    // 3x4: corners, ring turns, inner ring, positions past the end
    write_count(sosel_pkg::REG_ROW_COUNT, 3);
    write_count(sosel_pkg::REG_COL_COUNT, 4);
    queue_load(32'hffff_ffff);
    queue_load(32'h0000_0000);
    queue_load(32'h5555_5555);
    queue_load(32'haaaa_aaaa);
    for (int i = 4; i < 12; i++) queue_load(i * 32'h0101_0101);
    queue_query(1);
    queue_query(4);
    queue_query(6);
    queue_query(9);
    queue_query(12);
    queue_query(13);
    queue_query(8191);
    wait_drained();

    run_phase(2, 5, 12, 0);
    run_phase(0, 4, 10, 1);

    // counts above the maximum clamp to 64; only the first twelve entries
    // are known to be written at this point
    write_count(sosel_pkg::REG_ROW_COUNT, 127);
    write_count(sosel_pkg::REG_COL_COUNT, 0);
    queue_query(4);
    queue_query(65);
    queue_query(128);
    wait_drained();
    write_count(sosel_pkg::REG_ROW_COUNT, 1);
    write_count(sosel_pkg::REG_COL_COUNT, 127);
    queue_query(3);
    queue_query(65);
    queue_query(64 + 64);
    wait_drained();

    run_phase(3, 3, 12, 2);
    // leave the pointer past the 2x2 matrix of the next phase
    while (load_ptr < 4) begin
      queue_load($urandom());
      wait_drained();
    end
    run_phase(2, 2, 10, 3);
    run_phase($urandom_range(4, 1), $urandom_range(4, 1), 10, 0);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sosel_pkg.sv
rtl/core/sosel_if.sv
rtl/core/sosel_walk.sv
rtl/core/spiral_order_element_select.sv
tb/spiral_order_element_select_tb.sv
